>>> rtl/rsas_pkg.sv
// Shared constants, types and command/status structs for the rotated
// sorted array search unit. No dependencies.
package rsas_pkg;

  localparam int DEPTH      = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ITEM_BITS  = 32;
  localparam int REQ_BITS   = 2;
  localparam int IDX_BITS   = 10;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int PTR_BITS   = CNT_BITS + 1;

  typedef logic [ADDR_BITS-1:0]        addr_t;
  typedef logic [CNT_BITS-1:0]         cnt_t;
  typedef logic signed [PTR_BITS-1:0]  ptr_t;
  typedef logic signed [VALUE_BITS-1:0] val_t;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SEL_LO  = 2'd0,
    SEL_MID = 2'd1,
    SEL_HI  = 2'd2
  } sel_t;

  typedef struct packed {
    logic take;      // in ready
    sel_t sel;       // read address select
    logic cap_a;     // capture left element
    logic cap_m;     // capture middle element
    logic step;      // narrow the window
    logic set_hit;   // latch a hit at mid
    logic set_miss;  // latch not found
    logic push;      // move pending result to output
  } rsas_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic req_search;
    logic range_ok;   // lo <= hi
    logic hit;        // middle element equals target
    logic slot_free;  // output register can take a result
  } rsas_sts_t;

endpackage

>>> rtl/rsas_if.sv
// Channel interfaces for the rotated sorted array search unit:
// request, result and configuration write. Depends on rsas_pkg.
interface rsas_in_if;
  logic                             valid;
  logic                             ready;
  logic [rsas_pkg::REQ_BITS-1:0]    req_type;
  logic signed [rsas_pkg::ITEM_BITS-1:0] item_value;
  modport source (output valid, req_type, item_value, input ready);
  modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface rsas_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [rsas_pkg::IDX_BITS-1:0] found_index;
  modport source (output valid, found, found_index, input ready);
  modport sink   (input valid, found, found_index, output ready);
endinterface

interface rsas_cfg_if;
  logic valid;
  logic ready;
  logic allow_duplicates;
  modport source (output valid, allow_duplicates, input ready);
  modport sink   (input valid, allow_duplicates, output ready);
endinterface

>>> rtl/rsas_ctrl.sv
// Search sequencer: walks lo/mid/hi reads per probe and hands out the result.
// Depends on rsas_pkg.
module rsas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  rsas_pkg::rsas_sts_t sts,
  output rsas_pkg::rsas_cmd_t cmd
);
  import rsas_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD_LO  = 6'b000010,
    S_RD_MID = 6'b000100,
    S_RD_HI  = 6'b001000,
    S_EVAL   = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_LO;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid && sts.req_search) begin
          state_nxt = S_RD_LO;
        end
      end
      S_RD_LO: begin
        if (!sts.range_ok) begin
          cmd.set_miss = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.sel   = SEL_LO;
          state_nxt = S_RD_MID;
        end
      end
      S_RD_MID: begin
        cmd.sel   = SEL_MID;
        cmd.cap_a = 1'b1;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.sel   = SEL_HI;
        cmd.cap_m = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.hit) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_RD_LO;
        end
      end
      S_FIN: begin
        if (sts.slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // a search request always starts a probe
  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && sts.in_valid && sts.req_search) |=> (state_r == S_RD_LO))
    else $error("search request did not start a probe");

  // a result is only ever pushed once per search, then back to idle
  a_push_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> (state_r == S_IDLE))
    else $error("push did not return to idle");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

endmodule

>>> rtl/rsas_dp.sv
// Datapath: element store, count, search window, target and result registers.
// Depends on rsas_pkg and the channel interfaces in rsas_if.
module rsas_dp (
  input  logic                clk,
  input  logic                rst_n,
  rsas_in_if.sink             in_req,
  rsas_out_if.source          out_res,
  rsas_cfg_if.sink            cfg_wr,
  input  rsas_pkg::rsas_cmd_t cmd,
  output rsas_pkg::rsas_sts_t sts
);
  import rsas_pkg::*;

  val_t mem [DEPTH];
  val_t rdata_r;
  addr_t raddr;

  cnt_t count_r, count_nxt;
  ptr_t lo_r, lo_nxt, hi_r, hi_nxt, mid;
  val_t a_r, m_r, t_r, item_val;
  logic dup_r;
  logic res_found_r;
  logic [IDX_BITS-1:0] res_idx_r;
  logic out_valid_r, out_valid_nxt;
  logic out_found_r;
  logic [IDX_BITS-1:0] out_idx_r;
  logic accept, do_append, do_start;
  logic [63:0] item_ext;

  assign in_req.ready = cmd.take;
  assign cfg_wr.ready = 1'b1;
  assign accept       = in_req.valid && cmd.take;
  assign do_append    = accept && (req_t'(in_req.req_type) == REQ_APPEND)
                        && (count_r < cnt_t'(DEPTH));
  assign do_start     = accept && (req_t'(in_req.req_type) == REQ_SEARCH);

  // sign-extend the item, cut to element width
  assign item_ext = {{(64 - ITEM_BITS){in_req.item_value[ITEM_BITS-1]}}, in_req.item_value};
  assign item_val = val_t'(item_ext[VALUE_BITS-1:0]);

  assign mid = lo_r + ((hi_r - lo_r) >>> 1);

  always_comb begin
    case (cmd.sel)
      SEL_LO:  raddr = lo_r[ADDR_BITS-1:0];
      SEL_MID: raddr = mid[ADDR_BITS-1:0];
      SEL_HI:  raddr = hi_r[ADDR_BITS-1:0];
      default: raddr = lo_r[ADDR_BITS-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[count_r[ADDR_BITS-1:0]] <= item_val;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  always_comb begin
    count_nxt = count_r;
    if (accept && (req_t'(in_req.req_type) == REQ_CLEAR)) begin
      count_nxt = '0;
    end else if (do_append) begin
      count_nxt = count_r + cnt_t'(1);
    end
  end

  // window update; rdata_r holds the right element during the step
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (do_start) begin
      lo_nxt = '0;
      hi_nxt = ptr_t'({1'b0, count_r}) - ptr_t'(1);
    end else if (cmd.step) begin
      if (dup_r && (a_r == m_r) && (m_r == rdata_r)) begin
        lo_nxt = lo_r + ptr_t'(1);
        hi_nxt = hi_r - ptr_t'(1);
      end else if (a_r <= m_r) begin
        if ((a_r <= t_r) && (t_r < m_r)) begin
          hi_nxt = mid - ptr_t'(1);
        end else begin
          lo_nxt = mid + ptr_t'(1);
        end
      end else begin
        if ((m_r < t_r) && (t_r <= rdata_r)) begin
          lo_nxt = mid + ptr_t'(1);
        end else begin
          hi_nxt = mid - ptr_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (do_start) begin
      t_r <= item_val;
    end
    if (cmd.cap_a) begin
      a_r <= rdata_r;
    end
    if (cmd.cap_m) begin
      m_r <= rdata_r;
    end
    if (cmd.set_hit) begin
      res_found_r <= 1'b1;
      res_idx_r   <= mid[IDX_BITS-1:0];
    end else if (cmd.set_miss) begin
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
    end
    if (cmd.push) begin
      out_found_r <= res_found_r;
      out_idx_r   <= res_idx_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid) begin
        dup_r <= cfg_wr.allow_duplicates;
      end
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.found       = out_found_r;
  assign out_res.found_index = out_idx_r;

  assign sts.in_valid   = in_req.valid;
  assign sts.req_search = (req_t'(in_req.req_type) == REQ_SEARCH);
  assign sts.range_ok   = (lo_r <= hi_r);
  assign sts.hit        = (m_r == t_r);
  assign sts.slot_free  = !out_valid_r || out_res.ready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("element count above depth");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_res.ready))
    else $error("result pushed over an untaken result");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid_r)
    else $error("pushed result not shown");

endmodule

>>> rtl/rotated_sorted_array_search_unit.sv
// Rotated sorted array search unit: top level joining sequencer and datapath.
// Depends on rsas_pkg, rsas_if, rsas_ctrl and rsas_dp.
//
// Usage:
//   in_req  : requests. req_type 0 clears the store, 1 appends item_value,
//             2 searches for item_value; 3 is ignored. Appends past 1024
//             elements are dropped.
//   out_res : one result per search: found and found_index (0 on a miss).
//   cfg_wr  : writes allow_duplicates; always ready, write only while idle.
// Operation: clear and append complete as they are accepted. A search starts,
//   then runs probes, each of three reads through the element store's one read
//   port (left, middle, right) and a compare, and then finishes; roughly
//   ceil(log2(n+1)) probes, more when duplicates shrink the window at both ends.
// One request at a time: in_req.ready is high only while no search runs.
// The result register lets the next requests in while a result waits, but
// a search that finishes before out_res takes the previous result holds.
// Reset clears the element count, allow_duplicates and the result valid;
// the store contents are not cleared and need no clearing pass.
module rotated_sorted_array_search_unit (
  input  logic        clk,
  input  logic        rst_n,
  rsas_in_if.sink     in_req,
  rsas_out_if.source  out_res,
  rsas_cfg_if.sink    cfg_wr
);
  import rsas_pkg::*;

  rsas_cmd_t cmd;
  rsas_sts_t sts;

  rsas_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rsas_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

>>> tb/tb_rotated_sorted_array_search_unit.sv
// Self-checking bench for rotated_sorted_array_search_unit: queued requests with
// random gaps, an in-bench search predictor and an in-order result check.
// Depends on rsas_pkg, the rsas_if interfaces and the unit itself.
module tb_rotated_sorted_array_search_unit;
  import rsas_pkg::*;

  localparam int   STALL_LIMIT = 20000;
  localparam int   SETTLE      = 8;
  localparam val_t VAL_MIN     = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam val_t VAL_MAX     = {1'b0, {(VALUE_BITS-1){1'b1}}};

  typedef struct {
    req_t kind;
    val_t value;
  } array_op_t;

  typedef struct {
    logic                found;
    logic [IDX_BITS-1:0] index;
  } search_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rsas_in_if  in_ch ();
  rsas_out_if out_ch ();
  rsas_cfg_if cfg_ch ();

  rotated_sorted_array_search_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch),
    .cfg_wr  (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the unit's state
  val_t elem_store [DEPTH];
  int   elem_count;
  bit   dup_mode;

  array_op_t      op_queue [$];
  search_result_t awaited_results [$];
  int             loaded [$];

  int  ops_queued;
  int  ignored_queued;
  int  ops_taken;
  int  mismatch_count;
  int  quiet_cycles;
  bit  in_fire, out_fire, cfg_fire;
  bit  no_idle;
  int  in_gap, rx_gap, rx_stall, hold_request;
  array_op_t cur_op;

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic val_t rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return val_t'(int'($urandom_range(0, 20)) - 10);
      default: return val_t'($urandom);
    endcase
  endfunction

  // Binary search over a rotated sorted array, with optional equal-ends shrink
  function automatic search_result_t predict_search(input val_t target);
    search_result_t res;
    int   lo, hi, mid;
    val_t a, m, b;
    res.found = 1'b0;
    res.index = '0;
    lo = 0;
    hi = elem_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      a = elem_store[lo];
      m = elem_store[mid];
      b = elem_store[hi];
      if (m == target) begin
        res.found = 1'b1;
        res.index = mid[IDX_BITS-1:0];
        return res;
      end
      if (dup_mode && a == m && m == b) begin
        lo++;
        hi--;
      end else if (a <= m) begin
        if (a <= target && target < m) hi = mid - 1;
        else lo = mid + 1;
      end else begin
        if (m < target && target <= b) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input search_result_t want,
                               input logic got_found, input logic [IDX_BITS-1:0] got_index);
    if (mismatch_count < 10)
      $display("%0t: %s: expected found=%0d index=%0d, got found=%0d index=%0d",
               $realtime, what, want.found, want.index, got_found, got_index);
    mismatch_count++;
  endtask

  // Monitor: sample at the rising edge, update the mirror, check results
  always @(posedge clk) begin
    search_result_t want;
    bit progress;
    if (!rst_n) begin
      in_fire      <= 1'b0;
      out_fire     <= 1'b0;
      cfg_fire     <= 1'b0;
      elem_count   = 0;
      dup_mode     = 1'b0;
      quiet_cycles = 0;
    end else begin
      progress = 1'b0;
      in_fire  <= in_ch.valid && in_ch.ready;
      out_fire <= out_ch.valid && out_ch.ready;
      cfg_fire <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        dup_mode = cfg_ch.allow_duplicates;
        progress = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        case (req_t'(in_ch.req_type))
          REQ_CLEAR: elem_count = 0;
          REQ_APPEND: begin
            // drop the element once the store is full
            if (elem_count < DEPTH) begin
              elem_store[elem_count] = in_ch.item_value;
              elem_count++;
            end
          end
          REQ_SEARCH: awaited_results.push_back(predict_search(in_ch.item_value));
          default: ;
        endcase
        ops_taken++;
        progress = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          want.found = 1'b0;
          want.index = '0;
          flag_mismatch("result with none pending", want, out_ch.found, out_ch.found_index);
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.found !== want.found || out_ch.found_index !== want.index)
            flag_mismatch("result mismatch", want, out_ch.found, out_ch.found_index);
        end
        progress = 1'b1;
      end
      if (progress) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb_rotated_sorted_array_search_unit failed");
          $finish;
        end
      end
    end
  end

  // Request driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_ch.valid) in_gap = idle_draw();
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        cur_op = op_queue.pop_front();
        in_ch.req_type   <= cur_op.kind;
        in_ch.item_value <= cur_op.value;
        in_ch.valid      <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random gaps, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        rx_stall     = hold_request;
        hold_request = 0;
      end
      if (out_fire) rx_gap = idle_draw();
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_op(input req_t kind, input val_t value);
    array_op_t op;
    op.kind  = kind;
    op.value = value;
    op_queue.push_back(op);
    ops_queued++;
    if (kind == REQ_NONE) ignored_queued++;
  endtask

  // Hold until every request is taken and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (ops_taken != ops_queued || awaited_results.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_dup_mode(input bit on);
    @(negedge clk);
    cfg_ch.allow_duplicates <= on;
    cfg_ch.valid            <= 1'b1;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  // style: 0 spread values, 1 narrow range with duplicates, 2 all equal, 3 unsorted
  task automatic load_array(input int n, input int style);
    int vals [$];
    int k, v0;
    v0 = int'(rand_value());
    loaded = {};
    for (int i = 0; i < n; i++) begin
      case (style)
        1:       vals.push_back(int'($urandom_range(0, 6)) - 3);
        2:       vals.push_back(v0);
        default: vals.push_back(int'(rand_value()));
      endcase
    end
    if (style != 3) vals.sort();
    k = (n > 0) ? $urandom_range(0, n - 1) : 0;
    queue_op(REQ_CLEAR, rand_value());
    for (int i = 0; i < n; i++) begin
      loaded.push_back(vals[(i + k) % n]);
      queue_op(REQ_APPEND, val_t'(vals[(i + k) % n]));
    end
  endtask

  task automatic queue_searches(input int m);
    val_t t;
    for (int i = 0; i < m; i++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: t = loaded.size() > 0 ? val_t'(loaded[$urandom_range(0, loaded.size() - 1)])
                                       : rand_value();
        3: begin
          t = loaded.size() > 0 ? val_t'(loaded[$urandom_range(0, loaded.size() - 1)]) : '0;
          t = $urandom_range(0, 1) ? t + 1 : t - 1;
        end
        default: t = rand_value();
      endcase
      if ($urandom_range(0, 9) == 0) queue_op(REQ_NONE, rand_value());
      // stray append breaks the ordering now and then
      if ($urandom_range(0, 14) == 0) queue_op(REQ_APPEND, rand_value());
      queue_op(REQ_SEARCH, t);
    end
  endtask

  initial begin
    int phase;
    in_ch.valid             = 1'b0;
    in_ch.req_type          = REQ_NONE;
    in_ch.item_value        = '0;
    out_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.allow_duplicates = 1'b0;
    rst_n                   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, extremes, ignored type, rotated array, single element
    queue_op(REQ_SEARCH, '0);
    queue_op(REQ_NONE, val_t'(-1));
    queue_op(REQ_APPEND, 7);
    queue_op(REQ_APPEND, VAL_MAX);
    queue_op(REQ_APPEND, VAL_MIN);
    queue_op(REQ_APPEND, -5);
    queue_op(REQ_APPEND, 0);
    queue_op(REQ_SEARCH, VAL_MIN);
    queue_op(REQ_SEARCH, VAL_MAX);
    queue_op(REQ_SEARCH, 0);
    queue_op(REQ_SEARCH, -5);
    queue_op(REQ_SEARCH, 1);
    queue_op(REQ_CLEAR, '0);
    queue_op(REQ_SEARCH, -5);
    queue_op(REQ_APPEND, 42);
    queue_op(REQ_SEARCH, 42);
    queue_op(REQ_SEARCH, 41);
    drain();

    // Duplicates with equal ends
    write_dup_mode(1'b1);
    queue_op(REQ_CLEAR, '0);
    queue_op(REQ_APPEND, 3);
    queue_op(REQ_APPEND, 3);
    queue_op(REQ_APPEND, 3);
    queue_op(REQ_APPEND, 1);
    queue_op(REQ_APPEND, 3);
    queue_op(REQ_SEARCH, 1);
    queue_op(REQ_SEARCH, 3);
    queue_op(REQ_SEARCH, 2);
    drain();

    // Full store, then appends that must be dropped
    write_dup_mode(1'b0);
    load_array(DEPTH, 0);
    queue_op(REQ_APPEND, rand_value());
    queue_op(REQ_APPEND, rand_value());
    queue_op(REQ_SEARCH, val_t'(loaded[DEPTH-1]));
    queue_op(REQ_SEARCH, val_t'(loaded[0]));
    queue_op(REQ_SEARCH, val_t'(loaded[DEPTH/2]));
    queue_searches(6);
    drain();

    // Random phases: load a rotated array, then search it
    phase = 0;
    while (phase < 5 || ops_queued - ignored_queued < 800) begin
      if ($urandom_range(0, 1)) write_dup_mode($urandom_range(0, 1));
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:  load_array($urandom_range(0, 9) == 0 ?
                                   $urandom_range(40, 300) : $urandom_range(0, 24), 0);
        8, 9, 10, 11, 12, 13:    load_array($urandom_range(1, 24), 1);
        14, 15, 16:              load_array($urandom_range(1, 24), 2);
        default:                 load_array($urandom_range(1, 24), 3);
      endcase
      if (phase == 2) begin
        // long receiver hold-off while requests keep coming
        no_idle      = 1'b1;
        hold_request = 400;
        queue_searches(30);
      end else begin
        queue_searches($urandom_range(4, 16));
      end
      drain();
      phase++;
    end

    no_idle = 1'b0;
    drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("tb_rotated_sorted_array_search_unit passed");
    else
      $display("tb_rotated_sorted_array_search_unit failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/rsas_pkg.sv
rtl/rsas_if.sv
rtl/rsas_ctrl.sv
rtl/rsas_dp.sv
rtl/rotated_sorted_array_search_unit.sv
tb/tb_rotated_sorted_array_search_unit.sv
